### design/assert_macros.svh
// Assertion macros for the stereo allpass phaser.
// Bodies use the clk and arst_n names of the module that includes this file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SPA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define SPA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/spa_pkg.sv
// Shared types and constants of the stereo allpass phaser.
// No dependencies; imported by spa_cell, stereo_allpass_phaser and the test bench.
`timescale 1ns / 1ps

package spa_pkg;

	localparam int Q15_SHIFT = 15;
	localparam int Q15_RND   = 16384;
	localparam logic [15:0] MIX_UNITY = 16'h8000;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_STAGE_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WET_MIX       = 2'd2;

	localparam logic [3:0]  STAGE_COUNT_RST = 4'd4;
	localparam logic [15:0] WET_MIX_RST     = 16'd16384;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FEED,
		ST_RUN,
		ST_FIN
	} spa_state_t;

	// Token handed from cell to cell along with the sample pair.
	typedef struct packed {
		logic               valid;
		logic signed [15:0] coef;
	} spa_tok_t;

endpackage

### design/spa_cell.sv
// One first-order allpass stage for both channels, one cell of the row.
// Depends on spa_pkg; instantiated by stereo_allpass_phaser.
`timescale 1ns / 1ps

module spa_cell import spa_pkg::*; #(
	parameter int SAMPLE_BITS = 24,
	parameter int IDX = 0,
	parameter int NW = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [NW-1:0]                 stage_n,
	input  spa_tok_t                      tok_i,
	input  logic signed [SAMPLE_BITS-1:0] x_i [2],
	output spa_tok_t                      tok_o,
	output logic signed [SAMPLE_BITS-1:0] x_o [2]
);

	localparam int SW = SAMPLE_BITS;
	localparam int PW = SW + 17;
	localparam logic [NW-1:0] IDX_N = NW'(IDX);
	localparam logic signed [PW-1:0] SMAX = $signed({{(PW-SW+1){1'b0}}, {(SW-1){1'b1}}});
	localparam logic signed [PW-1:0] SMIN = ~SMAX;

	function automatic logic signed [SW-1:0] sat(input logic signed [PW-1:0] v);
		logic signed [SW-1:0] r;
		if (v > SMAX) begin
			r = SMAX[SW-1:0];
		end else if (v < SMIN) begin
			r = SMIN[SW-1:0];
		end else begin
			r = v[SW-1:0];
		end
		return r;
	endfunction

	logic signed [SW-1:0] pin_q  [2];
	logic signed [SW-1:0] pout_q [2];
	logic signed [SW-1:0] y      [2];
	logic signed [PW-1:0] diff   [2];
	logic signed [PW-1:0] prod   [2];
	logic signed [PW-1:0] sum    [2];
	logic                 upd;

	assign upd = tok_i.valid && (IDX_N < stage_n);

	always_comb begin
		for (int ch = 0; ch < 2; ch++) begin
			diff[ch] = PW'(pout_q[ch]) - PW'(x_i[ch]);
			prod[ch] = diff[ch] * PW'(tok_i.coef) + PW'(Q15_RND);
			sum[ch]  = PW'(pin_q[ch]) + (prod[ch] >>> Q15_SHIFT);
			y[ch]    = sat(sum[ch]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int ch = 0; ch < 2; ch++) begin
				pin_q[ch]  <= '0;
				pout_q[ch] <= '0;
			end
		end else if (upd) begin
			for (int ch = 0; ch < 2; ch++) begin
				pin_q[ch]  <= x_i[ch];
				pout_q[ch] <= y[ch];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_o <= '0;
		end else begin
			tok_o <= tok_i;
		end
	end

	// pass the sample through unchanged in a stage beyond the count
	always_ff @(posedge clk) begin
		for (int ch = 0; ch < 2; ch++) begin
			x_o[ch] <= upd ? y[ch] : x_i[ch];
		end
	end

endmodule

### design/stereo_allpass_phaser.sv
// Stereo phaser: feedback add, row of allpass cells, feedback update and mix.
// Depends on spa_pkg, spa_cell and assert_macros.svh.
`timescale 1ns / 1ps
// Usage:
//  Input channel in_valid/in_ready carries in_left, in_right and allpass_coef.
//  Output channel out_valid/out_ready carries out_left and out_right, one
//  result per input transfer, in order.
//  Config channel cfg_valid/cfg_ready (always ready) writes cfg_index 0
//  stage_count, 1 feedback_gain, 2 wet_mix from cfg_data; write only while idle.
//  From input transfer to out_valid an item passes the feedback add into the
//  head register, the register of each cell as the sample pair walks the row
//  of MAX_STAGES cells, the capture of the row output, and the feedback update
//  and mix into the output register. One item is in the row at a time and
//  in_ready returns in the same cycle that the result is posted, so a new
//  input transfer can follow only once the previous result is posted.
//  The result sits in an output register; the next item is accepted and
//  processed while it waits, and the block holds the following result until
//  the receiver takes the first.
//  Reset clears all stage state and the stored feedback, sets stage_count 4,
//  feedback_gain 0 and wet_mix 16384, and empties the output register.

`include "assert_macros.svh"

module stereo_allpass_phaser import spa_pkg::*; #(
	parameter int MAX_STAGES = 8,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] in_left,
	input  logic signed [SAMPLE_BITS-1:0] in_right,
	input  logic signed [15:0]            allpass_coef,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] out_left,
	output logic signed [SAMPLE_BITS-1:0] out_right,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [15:0]                   cfg_data
);

	localparam int SW = SAMPLE_BITS;
	localparam int PW = SW + 19;
	localparam int NW = $clog2(MAX_STAGES + 1);
	localparam int CW = (NW > 4) ? NW : 4;
	localparam logic signed [PW-1:0] SMAX = $signed({{(PW-SW+1){1'b0}}, {(SW-1){1'b1}}});
	localparam logic signed [PW-1:0] SMIN = ~SMAX;

	function automatic logic signed [SW-1:0] sat(input logic signed [PW-1:0] v);
		logic signed [SW-1:0] r;
		if (v > SMAX) begin
			r = SMAX[SW-1:0];
		end else if (v < SMIN) begin
			r = SMIN[SW-1:0];
		end else begin
			r = v[SW-1:0];
		end
		return r;
	endfunction

	// sample times Q2.15 value, rounded half up
	function automatic logic signed [PW-1:0] mq15(input logic signed [PW-1:0] s,
			input logic signed [16:0] q);
		logic signed [PW-1:0] p;
		p = s * PW'(q) + PW'(Q15_RND);
		return p >>> Q15_SHIFT;
	endfunction

	spa_state_t state_q, state_d;

	logic [3:0]           stage_count_q;
	logic signed [15:0]   feedback_gain_q;
	logic [15:0]          wet_mix_q;
	logic [CW-1:0]        stage_ext;
	logic [NW-1:0]        stage_n;
	logic [15:0]          mix_c;

	logic signed [SW-1:0] dry_q [2];
	logic signed [15:0]   coef_q;
	logic signed [SW-1:0] wet_q [2];
	logic signed [SW-1:0] fb_store_q;
	logic signed [SW-1:0] out_q [2];
	logic                 out_valid_q;

	spa_tok_t             head_tok_q;
	logic signed [SW-1:0] head_x_q [2];
	spa_tok_t             tok_c [MAX_STAGES+1];
	logic signed [SW-1:0] x_c   [MAX_STAGES+1][2];
	logic [MAX_STAGES:0]  tok_vec;

	logic                 in_xfer;
	logic                 head_load;
	logic                 fin_load;
	logic                 tail_valid;

	logic signed [PW-1:0] fb_add;
	logic signed [SW-1:0] feed_x [2];
	logic signed [PW-1:0] mean;
	logic signed [SW-1:0] fb_next;
	logic signed [SW-1:0] mix_o [2];

	assign cfg_ready = 1'b1;
	assign in_xfer   = in_valid && in_ready;
	assign tail_valid = tok_c[MAX_STAGES].valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_count_q   <= STAGE_COUNT_RST;
			feedback_gain_q <= '0;
			wet_mix_q       <= WET_MIX_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_STAGE_COUNT:   stage_count_q   <= cfg_data[3:0];
				CFG_FEEDBACK_GAIN: feedback_gain_q <= $signed(cfg_data);
				CFG_WET_MIX:       wet_mix_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	assign stage_ext = CW'(stage_count_q);
	assign stage_n   = (stage_ext > CW'(MAX_STAGES)) ? NW'(MAX_STAGES) : NW'(stage_ext);
	assign mix_c     = (wet_mix_q > MIX_UNITY) ? MIX_UNITY : wet_mix_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_FEED;
			ST_FEED: state_d = ST_RUN;
			ST_RUN:  if (tail_valid) state_d = ST_FIN;
			ST_FIN:  if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		head_load = (state_q == ST_FEED);
		fin_load  = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// feedback add into the head of the row
	always_comb begin
		fb_add = mq15(PW'(fb_store_q), 17'(feedback_gain_q));
		for (int ch = 0; ch < 2; ch++) begin
			feed_x[ch] = sat(PW'(dry_q[ch]) + fb_add);
		end
	end

	// feedback update and wet/dry mix
	always_comb begin
		mean    = (PW'(wet_q[0]) + PW'(wet_q[1])) >>> 1;
		fb_next = sat(mq15(mean, 17'(feedback_gain_q)));
		for (int ch = 0; ch < 2; ch++) begin
			mix_o[ch] = sat(PW'(dry_q[ch]) +
				mq15(PW'(wet_q[ch]) - PW'(dry_q[ch]), $signed({1'b0, mix_c})));
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			dry_q[0] <= in_left;
			dry_q[1] <= in_right;
			coef_q   <= allpass_coef;
		end
		if (head_load) begin
			head_x_q <= feed_x;
		end
		if (tail_valid) begin
			wet_q <= x_c[MAX_STAGES];
		end
		if (fin_load) begin
			out_q <= mix_o;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_tok_q  <= '0;
			fb_store_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			head_tok_q.valid <= head_load;
			head_tok_q.coef  <= coef_q;
			if (fin_load) begin
				fb_store_q <= fb_next;
			end
			if (fin_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign tok_c[0] = head_tok_q;
	assign x_c[0]   = head_x_q;

	for (genvar i = 0; i < MAX_STAGES; i++) begin : g_cell
		spa_cell #(
			.SAMPLE_BITS(SAMPLE_BITS),
			.IDX(i),
			.NW(NW)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.stage_n(stage_n),
			.tok_i(tok_c[i]),
			.x_i(x_c[i]),
			.tok_o(tok_c[i+1]),
			.x_o(x_c[i+1])
		);
	end

	always_comb begin
		for (int i = 0; i <= MAX_STAGES; i++) begin
			tok_vec[i] = tok_c[i].valid;
		end
	end

	assign out_valid = out_valid_q;
	assign out_left  = out_q[0];
	assign out_right = out_q[1];

	`SPA_ASSERT_IMP(a_one_token, 1'b1, $onehot0(tok_vec), "more than one item in the cell row")
	`SPA_ASSERT_IMP(a_tail_in_run, tail_valid, state_q == ST_RUN, "row output outside run state")
	`SPA_ASSERT_NEXT(a_xfer_feed, in_xfer, state_q == ST_FEED, "input transfer did not start feed")
	`SPA_ASSERT_NEXT(a_fin_out, fin_load, out_valid_q && state_q == ST_IDLE, "result not posted")

endmodule

### tb/sv/stereo_allpass_phaser_test.sv
`timescale 1ns / 1ps
// Self-checking bench for stereo_allpass_phaser: directed and random stereo frames under
// random stalls on both channels, checked against a behavioral allpass cascade predictor.
// Depends on spa_pkg and the stereo_allpass_phaser RTL.

module stereo_allpass_phaser_test;
	import spa_pkg::*;

	localparam int STAGE_MAX = 8;
	localparam int SAMPLE_W = 24;
	localparam longint SAMPLE_HI = (longint'(1) << (SAMPLE_W - 1)) - 1;
	localparam longint SAMPLE_LO = -SAMPLE_HI - 1;
	localparam logic signed [SAMPLE_W-1:0] S_MAX = SAMPLE_HI[SAMPLE_W-1:0];
	localparam logic signed [SAMPLE_W-1:0] S_MIN = SAMPLE_LO[SAMPLE_W-1:0];
	localparam logic signed [15:0] C_MAX = 16'sh7FFF;
	localparam logic signed [15:0] C_MIN = 16'sh8000;
	localparam int RAND_PHASES = 9;
	localparam int PHASE_FRAMES = 205;
	localparam int HOLD_AT = 150;
	localparam int HOLD_LEN = 400;
	localparam int CYCLE_LIMIT = 500000;
	localparam int IDLE_PCT [4] = '{0, 10, 30, 60};

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
		logic signed [15:0]         coef;
	} frame_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
	} stereo_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	logic signed [SAMPLE_W-1:0]   in_left = '0;
	logic signed [SAMPLE_W-1:0]   in_right = '0;
	logic signed [15:0]           allpass_coef = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic signed [SAMPLE_W-1:0]   out_left;
	logic signed [SAMPLE_W-1:0]   out_right;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [CFG_IDX_W-1:0]         cfg_index = '0;
	logic [15:0]                  cfg_data = '0;

	frame_t  frames_to_send [$];
	stereo_t expected_stereo_out [$];

	logic [3:0]         shadow_stages = STAGE_COUNT_RST;
	logic signed [15:0] shadow_gain = '0;
	logic [15:0]        shadow_mix = WET_MIX_RST;
	longint             tap_x_prev [2*STAGE_MAX] = '{default: 0};
	longint             tap_y_prev [2*STAGE_MAX] = '{default: 0};
	longint             fb_sample = 0;

	int      send_idle_pct = 0;
	int      recv_idle_pct = 0;
	int      send_gap;
	int      recv_gap;
	int      hold_left;
	bit      hold_done = 1'b0;
	int      results_seen;
	int      mismatches = 0;
	int      cycle_count = 0;
	frame_t  frame;
	stereo_t predicted;
	stereo_t want;

	stereo_allpass_phaser #(
		.MAX_STAGES(STAGE_MAX),
		.SAMPLE_BITS(SAMPLE_W)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_left(in_left),
		.in_right(in_right),
		.allpass_coef(allpass_coef),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_left(out_left),
		.out_right(out_right),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint clip_sample(input longint v);
		if (v > SAMPLE_HI)
			return SAMPLE_HI;
		if (v < SAMPLE_LO)
			return SAMPLE_LO;
		return v;
	endfunction

	function automatic longint q15_scale(input longint s, input longint g);
		return (s * g + Q15_RND) >>> Q15_SHIFT;
	endfunction

	function automatic void compute_phaser_output(
		input logic signed [SAMPLE_W-1:0] l,
		input logic signed [SAMPLE_W-1:0] r,
		input logic signed [15:0] coef,
		output stereo_t res
	);
		longint dry [2];
		longint x [2];
		longint fb_add;
		longint y;
		longint mix;
		int n;
		int k;
		dry[0] = l;
		dry[1] = r;
		n = (shadow_stages > STAGE_MAX) ? STAGE_MAX : int'(shadow_stages);
		fb_add = q15_scale(fb_sample, shadow_gain);
		for (int ch = 0; ch < 2; ch++)
			x[ch] = clip_sample(dry[ch] + fb_add);
		for (int st = 0; st < n; st++) begin
			for (int ch = 0; ch < 2; ch++) begin
				k = 2 * st + ch;
				y = clip_sample(tap_x_prev[k] + q15_scale(tap_y_prev[k] - x[ch], coef));
				tap_x_prev[k] = x[ch];
				tap_y_prev[k] = y;
				x[ch] = y;
			end
		end
		fb_sample = clip_sample(q15_scale((x[0] + x[1]) >>> 1, shadow_gain));
		mix = (shadow_mix > MIX_UNITY) ? longint'(MIX_UNITY) : longint'(shadow_mix);
		res.left = SAMPLE_W'(clip_sample(dry[0] + q15_scale(x[0] - dry[0], mix)));
		res.right = SAMPLE_W'(clip_sample(dry[1] + q15_scale(x[1] - dry[1], mix)));
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		logic [31:0] r;
		r = $urandom();
		case ($urandom_range(9))
			0: return S_MAX;
			1: return S_MIN;
			2, 3, 4: return SAMPLE_W'($signed(r[12:0]));
			default: return r[SAMPLE_W-1:0];
		endcase
	endfunction

	function automatic logic signed [15:0] pick_coef();
		logic [31:0] r;
		r = $urandom();
		case ($urandom_range(9))
			0: return C_MAX;
			1: return C_MIN;
			2: return '0;
			default: return r[15:0];
		endcase
	endfunction

	function automatic void queue_frame(
		input logic signed [SAMPLE_W-1:0] l,
		input logic signed [SAMPLE_W-1:0] r,
		input logic signed [15:0] c
	);
		frame_t f;
		f.left = l;
		f.right = r;
		f.coef = c;
		frames_to_send.push_back(f);
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (frames_to_send.size() != 0 || in_valid || expected_stereo_out.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_STAGE_COUNT: shadow_stages = cfg_data[3:0];
				CFG_FEEDBACK_GAIN: shadow_gain = cfg_data;
				CFG_WET_MIX: shadow_mix = cfg_data;
				default: ;
			endcase
		end
	end

	// Input driver: predict on each transfer, then offer the next frame or idle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (in_valid && in_ready) begin
				compute_phaser_output(in_left, in_right, allpass_coef, predicted);
				expected_stereo_out.push_back(predicted);
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (frames_to_send.size() == 0) begin
					in_valid <= 1'b0;
				end else if ($urandom_range(99) < send_idle_pct) begin
					send_gap = $urandom_range(14);
					in_valid <= 1'b0;
				end else begin
					frame = frames_to_send.pop_front();
					in_valid <= 1'b1;
					in_left <= frame.left;
					in_right <= frame.right;
					allpass_coef <= frame.coef;
				end
			end
		end
	end

	// Output monitor: check each transfer, drive out_ready with stalls and one long hold.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap = 0;
			hold_left = 0;
			results_seen = 0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_stereo_out.size() == 0) begin
					$error("result with nothing expected: out_left %0d out_right %0d",
						out_left, out_right);
					mismatches++;
				end else begin
					want = expected_stereo_out.pop_front();
					if (out_left !== want.left) begin
						$error("out_left: expected %0d, actual %0d", want.left, out_left);
						mismatches++;
					end
					if (out_right !== want.right) begin
						$error("out_right: expected %0d, actual %0d", want.right, out_right);
						mismatches++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!hold_done && results_seen >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_LEN - 1;
				out_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else if ($urandom_range(99) < recv_idle_pct) begin
				recv_gap = $urandom_range(14);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("stereo_allpass_phaser test failed");
			$finish;
		end
	end

	initial begin
		logic [15:0] gain_val;
		logic [15:0] mix_val;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: four stages, no feedback, half wet.
		queue_frame('0, '0, '0);
		queue_frame(S_MAX, S_MIN, C_MAX);
		queue_frame(S_MIN, S_MAX, C_MIN);
		queue_frame(S_MAX, S_MAX, C_MIN);
		queue_frame(S_MIN, S_MIN, C_MAX);
		queue_frame(24'sd1, -24'sd1, 16'sd16384);
		drain();

		// Stage count clamp, full feedback, mix clamp; drive into saturation.
		write_reg(CFG_STAGE_COUNT, 16'd15);
		write_reg(CFG_FEEDBACK_GAIN, C_MAX);
		write_reg(CFG_WET_MIX, 16'hFFFF);
		send_idle_pct = 30;
		recv_idle_pct = 30;
		queue_frame(S_MAX, S_MAX, C_MAX);
		queue_frame(S_MAX, S_MAX, C_MIN);
		queue_frame(S_MIN, S_MIN, '0);
		queue_frame(S_MIN, S_MAX, C_MIN);
		drain();

		// Bypass the chain.
		write_reg(CFG_STAGE_COUNT, 16'd0);
		write_reg(CFG_FEEDBACK_GAIN, C_MIN);
		write_reg(CFG_WET_MIX, MIX_UNITY);
		queue_frame(S_MAX, S_MIN, C_MAX);
		queue_frame(S_MIN, S_MIN, C_MIN);
		queue_frame(24'sd4096, -24'sd8192, 16'sd12345);
		drain();

		// Fully dry with two stages; upper stages hold their state.
		write_reg(CFG_STAGE_COUNT, 16'd2);
		write_reg(CFG_FEEDBACK_GAIN, '0);
		write_reg(CFG_WET_MIX, '0);
		queue_frame(S_MAX, S_MIN, C_MIN);
		queue_frame(-24'sd1, 24'sd1, C_MAX);
		queue_frame(24'sd100000, -24'sd100000, -16'sd20000);
		drain();

		write_reg(CFG_STAGE_COUNT, 16'd8);
		write_reg(CFG_FEEDBACK_GAIN, 16'd16384);
		write_reg(CFG_WET_MIX, 16'd32769);
		queue_frame('0, '0, C_MAX);
		queue_frame(S_MAX, S_MIN, -16'sd1);
		queue_frame(24'sd300000, 24'sd200000, 16'sd30000);
		drain();

		for (int p = 0; p < RAND_PHASES; p++) begin
			case ($urandom_range(3))
				0: gain_val = C_MAX;
				1: gain_val = C_MIN;
				2: gain_val = '0;
				default: gain_val = 16'($urandom());
			endcase
			case ($urandom_range(3))
				0: mix_val = MIX_UNITY;
				1: mix_val = '0;
				2: mix_val = 16'($urandom_range(32768));
				default: mix_val = 16'($urandom());
			endcase
			write_reg(CFG_STAGE_COUNT, 16'($urandom_range(15)));
			write_reg(CFG_FEEDBACK_GAIN, gain_val);
			write_reg(CFG_WET_MIX, mix_val);
			if (p == RAND_PHASES - 1) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else begin
				send_idle_pct = IDLE_PCT[$urandom_range(3)];
				recv_idle_pct = IDLE_PCT[$urandom_range(3)];
			end
			repeat (PHASE_FRAMES)
				queue_frame(pick_sample(), pick_sample(), pick_coef());
			drain();
		end

		repeat (2 * (STAGE_MAX + 3)) @(posedge clk);
		if (mismatches == 0 && expected_stereo_out.size() == 0)
			$display("stereo_allpass_phaser test passed");
		else
			$display("stereo_allpass_phaser test failed");
		$finish;
	end

endmodule

### files.f
+incdir+design
design/spa_pkg.sv
design/spa_cell.sv
design/stereo_allpass_phaser.sv
tb/sv/stereo_allpass_phaser_test.sv
